@@ sv/sle_pkg.sv @@
package sle_pkg;

   // widest count the cells support (CAPACITY up to 1024)
   localparam int CNT_W_MAX = 11;
   localparam int DATA_W    = 32;

   localparam logic [6:0] NONE_FOUND = 7'h7F;

   typedef enum logic [2:0] {
      CMD_APPEND       = 3'd0,
      CMD_REMOVE_LAST  = 3'd1,
      CMD_PREPEND      = 3'd2,
      CMD_REMOVE_FIRST = 3'd3,
      CMD_SEARCH       = 3'd4,
      CMD_INSERT       = 3'd5,
      CMD_ERASE        = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                  shift_up;    // take left neighbor for lo < i <= hi
      logic                  write;       // load value at i == lo
      logic                  shift_down;  // take right neighbor for lo <= i < hi-1
      logic                  clear;       // zero the cell at i == hi-1
      logic                  load_hits;   // capture compare results
      logic                  shift_hits;  // move hit bits one cell toward the head
      logic [CNT_W_MAX-1:0]  lo;
      logic [CNT_W_MAX-1:0]  hi;
      logic [CNT_W_MAX-1:0]  first;
      logic [DATA_W-1:0]     value;
   } ctrl_type;

endpackage

@@ sv/sle_cell.sv @@
module sle_cell #(
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sle_pkg::ctrl_type           ctrl,
   input  logic [sle_pkg::DATA_W-1:0]  left_element,
   input  logic [sle_pkg::DATA_W-1:0]  right_element,
   input  logic                        right_hit,
   output logic [sle_pkg::DATA_W-1:0]  element,
   output logic                        hit
);

   localparam logic [sle_pkg::CNT_W_MAX-1:0] IDX    = sle_pkg::CNT_W_MAX'(INDEX);
   localparam logic [sle_pkg::CNT_W_MAX-1:0] IDX_P1 = sle_pkg::CNT_W_MAX'(INDEX + 1);

   logic [sle_pkg::DATA_W-1:0] element_ff;
   logic [sle_pkg::DATA_W-1:0] element_in;
   logic                       hit_ff;
   logic                       hit_in;
   logic                       match;

   always_comb begin
      priority if (ctrl.shift_up && (IDX > ctrl.lo) && (IDX <= ctrl.hi)) begin
         element_in = left_element;
      end else if (ctrl.write && (IDX == ctrl.lo)) begin
         element_in = ctrl.value;
      end else if (ctrl.shift_down && (IDX >= ctrl.lo) && (IDX_P1 < ctrl.hi)) begin
         element_in = right_element;
      end else if (ctrl.clear && (IDX_P1 == ctrl.hi)) begin
         element_in = '0;
      end else begin
         element_in = element_ff;
      end
   end

   assign match = (IDX >= ctrl.first) && (IDX < ctrl.hi) && (element_ff == ctrl.value);

   always_comb begin
      priority if (ctrl.load_hits) begin
         hit_in = match;
      end else if (ctrl.shift_hits) begin
         hit_in = right_hit;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      element_ff <= element_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign element = element_ff;
   assign hit     = hit_ff;

endmodule

@@ sv/sequential_list_engine_top.sv @@
// channel   | ports                                              | handshake
// request   | req_cmd req_position req_start_index req_value     | start & !busy
// response  | rsp_status rsp_found_index rsp_element_count       | rsp_strobe, one cycle
//
// Every command but search is taken without a busy state; busy stays low and its word
// strobes on the next cycle, so one command a cycle is sustained between searches.
// Search loads the compare hits of all cells, then walks the hit chain one cell
// a cycle: busy stays high until the first match at or after the start index reaches
// the head, or the walk reaches the last element if none; the word strobes the cycle after.
// Reset is synchronous and clears the count, the FSM and the response strobe;
// element contents are undefined until written. The receiver cannot stall.
module sequential_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [5:0]         req_position,
   input  logic [5:0]         req_start_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [6:0]  rsp_found_index,
   output logic [6:0]         rsp_element_count
);

   localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CPW = CW + 6;
   localparam int MW  = sle_pkg::CNT_W_MAX;

   sle_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  scan_idx_ff, scan_idx_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [6:0]     rsp_found_ff, rsp_found_in;
   logic [6:0]     rsp_count_ff, rsp_count_in;

   sle_pkg::ctrl_type ctrl;
   sle_pkg::cmd_type  cmd;
   sle_pkg::status_type status;

   logic accept;
   logic full;
   logic empty;
   logic start_past;
   logic scan_last;
   logic head_hit;
   logic [CPW-1:0] pos_ext;
   logic [CPW-1:0] cnt_ext;

   logic [sle_pkg::DATA_W-1:0] cell_element [CAPACITY+1];
   logic                       cell_hit     [CAPACITY+1];

   assign cmd        = sle_pkg::cmd_type'(req_cmd);
   assign accept     = start && (state_ff == sle_pkg::S_IDLE);
   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign pos_ext    = CPW'(req_position);
   assign cnt_ext    = CPW'(count_ff);
   assign start_past = (CPW'(req_start_index) >= cnt_ext);
   assign scan_last  = ((CW'(scan_idx_ff) + CW'(1)) >= count_ff);
   assign head_hit   = cell_hit[0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            if (accept && (cmd == sle_pkg::CMD_SEARCH)) begin
               state_in = sle_pkg::S_SCAN;
            end
         end
         sle_pkg::S_SCAN: begin
            if (head_hit || scan_last) begin
               state_in = sle_pkg::S_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl          = '0;
      ctrl.value    = req_value;
      ctrl.hi       = MW'(count_ff);
      status        = sle_pkg::ST_OK;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      busy          = 1'b0;
      unique case (state_ff)
         sle_pkg::S_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  sle_pkg::CMD_APPEND: begin
                     if (full) begin
                        status = sle_pkg::ST_FULL;
                     end else begin
                        ctrl.write = 1'b1;
                        ctrl.lo    = MW'(count_ff);
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  sle_pkg::CMD_REMOVE_LAST: begin
                     if (empty) begin
                        status = sle_pkg::ST_EMPTY;
                     end else begin
                        ctrl.clear = 1'b1;
                        count_in   = count_ff - CW'(1);
                     end
                  end
                  sle_pkg::CMD_PREPEND: begin
                     if (full) begin
                        status = sle_pkg::ST_FULL;
                     end else begin
                        ctrl.shift_up = 1'b1;
                        ctrl.write    = 1'b1;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  sle_pkg::CMD_REMOVE_FIRST: begin
                     if (empty) begin
                        status = sle_pkg::ST_EMPTY;
                     end else begin
                        ctrl.shift_down = 1'b1;
                        ctrl.clear      = 1'b1;
                        count_in        = count_ff - CW'(1);
                     end
                  end
                  sle_pkg::CMD_SEARCH: begin
                     ctrl.load_hits = 1'b1;
                     // a start beyond the end masks every cell
                     ctrl.first     = start_past ? MW'(count_ff) : MW'(req_start_index);
                     scan_idx_in    = '0;
                  end
                  sle_pkg::CMD_INSERT: begin
                     if (full) begin
                        status = sle_pkg::ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        status = sle_pkg::ST_BADPOS;
                     end else begin
                        ctrl.shift_up = 1'b1;
                        ctrl.write    = 1'b1;
                        ctrl.lo       = MW'(req_position);
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  sle_pkg::CMD_ERASE: begin
                     if (empty) begin
                        status = sle_pkg::ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        status = sle_pkg::ST_BADPOS;
                     end else begin
                        ctrl.shift_down = 1'b1;
                        ctrl.clear      = 1'b1;
                        ctrl.lo         = MW'(req_position);
                        count_in        = count_ff - CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
               if (cmd != sle_pkg::CMD_SEARCH) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = status;
                  rsp_found_in  = sle_pkg::NONE_FOUND;
                  rsp_count_in  = 7'(count_in);
               end
            end
         end
         sle_pkg::S_SCAN: begin
            busy = 1'b1;
            if (head_hit || scan_last) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = sle_pkg::ST_OK;
               rsp_found_in  = head_hit ? 7'(scan_idx_ff) : sle_pkg::NONE_FOUND;
               rsp_count_in  = 7'(count_ff);
            end else begin
               ctrl.shift_hits = 1'b1;
               scan_idx_in     = scan_idx_ff + IW'(1);
            end
         end
      endcase
   end

   assign cell_element[CAPACITY] = '0;
   assign cell_hit[CAPACITY]     = 1'b0;

   logic [sle_pkg::DATA_W-1:0] left_of [CAPACITY];

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign left_of[g] = '0;
         end else begin : g_body
            assign left_of[g] = cell_element[g-1];
         end
         sle_cell #(
            .INDEX(g)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (ctrl),
            .left_element  (left_of[g]),
            .right_element (cell_element[g+1]),
            .right_hit     (cell_hit[g+1]),
            .element       (cell_element[g]),
            .hit           (cell_hit[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sle_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_index   = rsp_found_ff;
   assign rsp_element_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count above capacity");

   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (status != sle_pkg::ST_OK)) |=> (count_ff == $past(count_ff)))
      else $error("count changed on a rejected command");

   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_found_ff != sle_pkg::NONE_FOUND))
         |-> (rsp_status_ff == sle_pkg::ST_OK))
      else $error("found index with error status");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sle_pkg::S_SCAN) && (head_hit || scan_last)) |=> rsp_strobe_ff)
      else $error("search finished without a response word");

endmodule

@@ tb/list_engine_checker.sv @@
`timescale 1ns / 1ps

module list_engine_checker #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [5:0]         req_position,
   input  logic [5:0]         req_start_index,
   input  logic signed [31:0] req_value,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_status,
   input  logic signed [6:0]  rsp_found_index,
   input  logic [6:0]         rsp_element_count,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      sle_pkg::status_type status;
      logic signed [6:0]   found;
      logic [6:0]          count;
   } list_word_type;

   logic signed [31:0] list_elems [CAPACITY];
   int                 list_len;
   list_word_type      due_words [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      list_len   = 0;
   end

   task automatic report_fail(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // one command against the shadow list; returns the word it should produce
   function automatic list_word_type apply_list_command(input logic [2:0] cmd,
                                                        input logic [5:0] pos,
                                                        input logic [5:0] first,
                                                        input logic signed [31:0] val);
      list_word_type w;
      int            i;
      bit            hit;
      w.status = sle_pkg::ST_OK;
      w.found  = sle_pkg::NONE_FOUND;
      hit      = 1'b0;
      case (cmd)
         sle_pkg::CMD_APPEND: begin
            if (list_len >= CAPACITY) begin
               w.status = sle_pkg::ST_FULL;
            end else begin
               list_elems[list_len] = val;
               list_len++;
            end
         end
         sle_pkg::CMD_REMOVE_LAST: begin
            if (list_len == 0) w.status = sle_pkg::ST_EMPTY;
            else list_len--;
         end
         sle_pkg::CMD_PREPEND, sle_pkg::CMD_INSERT: begin
            if (list_len >= CAPACITY) begin
               w.status = sle_pkg::ST_FULL;
            end else if (cmd == sle_pkg::CMD_INSERT && int'(pos) > list_len) begin
               w.status = sle_pkg::ST_BADPOS;
            end else begin
               for (i = list_len; i > ((cmd == sle_pkg::CMD_INSERT) ? int'(pos) : 0); i--)
                  list_elems[i] = list_elems[i-1];
               list_elems[(cmd == sle_pkg::CMD_INSERT) ? int'(pos) : 0] = val;
               list_len++;
            end
         end
         sle_pkg::CMD_REMOVE_FIRST, sle_pkg::CMD_ERASE: begin
            if (list_len == 0) begin
               w.status = sle_pkg::ST_EMPTY;
            end else if (cmd == sle_pkg::CMD_ERASE && int'(pos) >= list_len) begin
               w.status = sle_pkg::ST_BADPOS;
            end else begin
               for (i = (cmd == sle_pkg::CMD_ERASE) ? int'(pos) : 0; i + 1 < list_len; i++)
                  list_elems[i] = list_elems[i+1];
               list_len--;
            end
         end
         sle_pkg::CMD_SEARCH: begin
            for (i = int'(first); i < list_len && !hit; i++) begin
               if (list_elems[i] == val) begin
                  w.found = i[6:0];
                  hit     = 1'b1;
               end
            end
         end
         default: ;
      endcase
      w.count = list_len[6:0];
      return w;
   endfunction

   always @(posedge clock) begin
      list_word_type want;
      if (!reset) begin
         // drain the oldest word first: a word never strobes in its accept cycle
         if (rsp_strobe === 1'b1) begin
            if (due_words.size() == 0) begin
               report_fail($sformatf("word with none expected (status %0d count %0d)",
                                     rsp_status, rsp_element_count));
            end else begin
               want = due_words.pop_front();
               if (rsp_status !== want.status)
                  report_fail($sformatf("status got %0d want %0d", rsp_status,
                                        want.status));
               if (rsp_found_index !== want.found)
                  report_fail($sformatf("found_index got %0d want %0d",
                                        rsp_found_index, want.found));
               if (rsp_element_count !== want.count)
                  report_fail($sformatf("element_count got %0d want %0d",
                                        rsp_element_count, want.count));
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_fail("rsp_strobe unknown");
         end
         if (start && busy === 1'b0)
            due_words.push_back(apply_list_command(req_cmd, req_position,
                                                   req_start_index, req_value));
      end
      pending = due_words.size();
   end

endmodule

@@ tb/tb_sequential_list_engine_top.sv @@
`timescale 1ns / 1ps

module tb_sequential_list_engine_top;

   localparam int         CAPACITY     = 64;
   localparam int         RANDOM_WORDS = 600;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [2:0] CMD_UNUSED   = 3'd7;

   typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_cmd = '0;
   logic [5:0]         req_position = '0;
   logic [5:0]         req_start_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [6:0]  rsp_found_index;
   logic [6:0]         rsp_element_count;
   int                 fail_count;
   int                 pending;
   int                 cycle_count;
   int                 shadow_len;
   bit                 quiet_phase;

   always #10 clock = ~clock;

   sequential_list_engine_top #(.CAPACITY(CAPACITY)) dut (.*);

   list_engine_checker #(.CAPACITY(CAPACITY)) checker_i (.*);

   // called at a rising edge; returns at the edge that takes the word
   task automatic issue_word(input logic [2:0] c, input logic [5:0] p,
                             input logic [5:0] s, input logic [31:0] v);
      req_cmd         <= c;
      req_position    <= p;
      req_start_index <= s;
      req_value       <= v;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      // length only, so the generator can aim positions inside the list
      case (c)
         sle_pkg::CMD_APPEND, sle_pkg::CMD_PREPEND:
            if (shadow_len < CAPACITY) shadow_len++;
         sle_pkg::CMD_INSERT:
            if (shadow_len < CAPACITY && int'(p) <= shadow_len) shadow_len++;
         sle_pkg::CMD_REMOVE_LAST, sle_pkg::CMD_REMOVE_FIRST:
            if (shadow_len > 0) shadow_len--;
         sle_pkg::CMD_ERASE: if (int'(p) < shadow_len) shadow_len--;
         default: ;
      endcase
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // small pool of values so searches hit at varied positions
   function automatic logic [31:0] pick_value(input int pool_pct);
      if ($urandom_range(0, 99) >= pool_pct) return $urandom;
      case ($urandom_range(0, 6))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0000_0001;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return 32'h5A5A_5A5A;
         default: return 32'h0000_1234;
      endcase
   endfunction

   task automatic random_word(input phase_kind_type kind);
      int          r;
      int          add_pct;
      int          search_pct;
      int          top_pos;
      logic [2:0]  c;
      logic [5:0]  p;
      logic [5:0]  s;
      logic [31:0] v;
      add_pct    = (kind == PH_GROW) ? 70 : (kind == PH_SHRINK) ? 12 : 40;
      search_pct = (kind == PH_GROW) ? 15 : (kind == PH_SHRINK) ? 14 : 20;
      top_pos    = (shadow_len > 63) ? 63 : shadow_len;
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
         case ($urandom_range(0, 2))
            0: c = sle_pkg::CMD_APPEND;
            1: c = sle_pkg::CMD_PREPEND;
            default: c = sle_pkg::CMD_INSERT;
         endcase
      end else if (r < add_pct + search_pct) begin
         c = sle_pkg::CMD_SEARCH;
      end else if (r < 98) begin
         case ($urandom_range(0, 2))
            0: c = sle_pkg::CMD_REMOVE_LAST;
            1: c = sle_pkg::CMD_REMOVE_FIRST;
            default: c = sle_pkg::CMD_ERASE;
         endcase
      end else begin
         c = CMD_UNUSED;
      end
      p = $urandom_range(0, 63);
      s = $urandom_range(0, 63);
      if (c == sle_pkg::CMD_INSERT && $urandom_range(0, 99) < 85)
         p = $urandom_range(0, top_pos);
      if (c == sle_pkg::CMD_ERASE && shadow_len > 0 && $urandom_range(0, 99) < 85)
         p = $urandom_range(0, shadow_len - 1);
      if (c == sle_pkg::CMD_SEARCH && $urandom_range(0, 99) < 70)
         s = $urandom_range(0, top_pos);
      v = pick_value((c == sle_pkg::CMD_SEARCH) ? 70 : 50);
      issue_word(c, p, s, v);
   endtask

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int             done;
      int             phase_len;
      phase_kind_type kind;
      shadow_len  = 0;
      quiet_phase = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners, then edge positions, searches and erases on a short list
      issue_word(sle_pkg::CMD_REMOVE_LAST, 6'd0, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_REMOVE_FIRST, 6'd0, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_ERASE, 6'd0, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_INSERT, 6'd1, 6'd0, 32'h1111_1111);
      issue_word(sle_pkg::CMD_INSERT, 6'd0, 6'd0, 32'h0000_0001);
      issue_word(sle_pkg::CMD_APPEND, 6'd63, 6'd63, 32'h7FFF_FFFF);
      issue_word(sle_pkg::CMD_PREPEND, 6'd0, 6'd0, 32'h8000_0000);
      issue_word(sle_pkg::CMD_INSERT, 6'd3, 6'd0, 32'hFFFF_FFFF);
      issue_word(sle_pkg::CMD_INSERT, 6'd5, 6'd0, 32'h2222_2222);
      idle_cycles(3);
      issue_word(sle_pkg::CMD_INSERT, 6'd1, 6'd0, 32'hFFFF_FFFF);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd0, 32'h8000_0000);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd63, 32'h8000_0000);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd2, 32'hFFFF_FFFF);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd5, 32'hFFFF_FFFF);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd0, 32'h3333_3333);
      issue_word(sle_pkg::CMD_ERASE, 6'd63, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_ERASE, 6'd5, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_ERASE, 6'd1, 6'd0, 32'h0);
      issue_word(CMD_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF);
      issue_word(sle_pkg::CMD_REMOVE_FIRST, 6'd0, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_REMOVE_LAST, 6'd0, 6'd0, 32'h0);
      issue_word(sle_pkg::CMD_SEARCH, 6'd0, 6'd0, 32'h0000_0001);

      // phases bias the list toward full, toward empty, or hold it level
      done = 0;
      kind = PH_GROW;
      while (done < RANDOM_WORDS) begin
         phase_len   = $urandom_range(80, 140);
         if (phase_len > RANDOM_WORDS - done) phase_len = RANDOM_WORDS - done;
         quiet_phase = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            idle_cycles(pick_gap());
            random_word(kind);
            done++;
         end
         case (kind)
            PH_GROW:   kind = PH_MIX;
            PH_MIX:    kind = (shadow_len > 32) ? PH_SHRINK : PH_GROW;
            default:   kind = PH_GROW;
         endcase
      end
      start <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sequential_list_engine_top.sv
tb/list_engine_checker.sv
tb/tb_sequential_list_engine_top.sv
